// ----- hw/rtl/slider_record_parser_defines.svh -----
// Assertion macros for the slider record parser.
// Used by slider_record_parser.sv; expects clk and rst_n in scope.
`ifndef SLIDER_RECORD_PARSER_DEFINES_SVH
`define SLIDER_RECORD_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// checked only outside reset
`define SLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define SLP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLP_ASSERT(lbl, prop, msg)
`define SLP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hw/rtl/slp_pkg.sv -----
// Shared types and constants for the slider record parser.
// No dependencies.
package slp_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_UPDATE    = 2'd0;
  localparam kind_t KIND_BAD_INDEX = 2'd1;
  localparam kind_t KIND_FAILURE   = 2'd2;
  localparam kind_t KIND_READ      = 2'd3;

  typedef logic [2:0] phase_t;

  localparam phase_t PH_IDLE = 3'd0;  // between messages
  localparam phase_t PH_IDX2 = 3'd1;  // second index char next
  localparam phase_t PH_SEP  = 3'd2;  // separator next
  localparam phase_t PH_VAL1 = 3'd3;  // first value char next
  localparam phase_t PH_VAL4 = 3'd6;  // last value char next

  localparam logic [7:0] CH_FAIL    = 8'h46;  // 'F'
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  typedef struct packed {
    logic       ok;
    logic [3:0] dig;
  } hex_t;

  // Hex digit decode: 0-9, a-f, A-F.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      h.ok = 1'b1;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
      d = c - CH_LOWER_A + 8'd10;
      h.ok = 1'b1;
    end else if (c >= CH_UPPER_A && c <= CH_FAIL) begin
      d = c - CH_UPPER_A + 8'd10;
      h.ok = 1'b1;
    end
    h.dig = d[3:0];
    return h;
  endfunction

  // Characters that open a slider record: 0-9 and a-f only.
  function automatic logic is_record_start(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LOWER_A && c <= CH_LOWER_F);
  endfunction

endpackage

// ----- hw/rtl/slider_record_parser.sv -----
// Slider record parser: byte-wise decoder of slider board messages with a value table.
// Depends on slp_pkg and slider_record_parser_defines.svh.
//
//   channel | direction | ports                                         | per request
//   --------+-----------+-----------------------------------------------+---------------------
//   in_     | input     | in_valid, in_stall, in_mode, in_rx_byte,      | one byte or one
//           |           | in_query_index                                | read-back query
//   out_    | output    | out_valid, out_stall, out_kind,               | zero or one result
//           |           | out_slider_num, out_slider_value,             |
//           |           | out_failed_slave                              |
//
// Cycles: one request per cycle while in_stall is low. A result shows on the out_ ports in the
//   cycle after its request is taken; the parse state and the output register are the only pipeline.
// Reset: synchronous, active low; clears the parse state, the output valid and the
//   per-entry valid bits of the table, so every slider reads zero right after reset.
// Stalls: in_stall is high only while a result is held and out_stall is high; a result
//   waiting in the output register does not block a request once it is taken.
`include "slider_record_parser_defines.svh"

module slider_record_parser #(
  parameter int SLIDER_COUNT = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  // request side
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_mode,
  input  logic [7:0]      in_rx_byte,
  input  logic [7:0]      in_query_index,
  // result side
  output logic            out_valid,
  input  logic            out_stall,
  output slp_pkg::kind_t  out_kind,
  output logic [7:0]      out_slider_num,
  output logic [15:0]     out_slider_value,
  output logic [7:0]      out_failed_slave
);
  import slp_pkg::*;

  // table address width; one bit minimum so a single-entry table still has an address
  localparam int AW = (SLIDER_COUNT > 1) ? $clog2(SLIDER_COUNT) : 1;
  localparam logic [8:0] CNT9 = 9'(SLIDER_COUNT);

  // ---------------------------------------------------------------------------
  // parse state
  // ---------------------------------------------------------------------------
  phase_t       phase_r,  phase_nxt;
  logic         fail_r,   fail_nxt;    // 'F' seen, slave byte next
  logic [7:0]   idx_r,    idx_nxt;
  logic         istop_r,  istop_nxt;   // index field ended by a non-hex char
  logic [15:0]  val_r,    val_nxt;
  logic         vstop_r,  vstop_nxt;

  // output register
  logic         out_valid_r;
  kind_t        out_kind_r;
  logic [7:0]   out_idx_r;
  logic [15:0]  out_val_r;
  logic [7:0]   out_slave_r;

  // value table with registered read port and per-entry valid bits
  logic [15:0]             mem [SLIDER_COUNT];
  logic [SLIDER_COUNT-1:0] vld_r;
  logic [15:0]             rd_data_r;
  logic                    rd_hit_r;

  logic         in_acc;
  hex_t         hx;
  logic         res_v;
  kind_t        res_kind;
  logic [7:0]   res_idx;
  logic [15:0]  res_val;
  logic [7:0]   res_slave;
  logic         wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic         q_in_range;
  logic         idx_in_range;
  logic [15:0]  val_new;
  logic         vstop_new;

  // a request is only held back when a result is waiting and the sink stalls
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  assign hx           = hex_decode(in_rx_byte);
  assign q_in_range   = {1'b0, in_query_index} < CNT9;
  assign idx_in_range = {1'b0, idx_r} < CNT9;
  assign rd_addr      = in_query_index[AW-1:0];
  assign wr_addr      = idx_r[AW-1:0];

  // value digit shift, shared by all four value positions
  always_comb begin
    val_new   = val_r;
    vstop_new = 1'b1;
    if (!vstop_r && hx.ok) begin
      val_new   = {val_r[11:0], hx.dig};
      vstop_new = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // next state and result for the request at the port
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_nxt = phase_r;
    fail_nxt  = fail_r;
    idx_nxt   = idx_r;
    istop_nxt = istop_r;
    val_nxt   = val_r;
    vstop_nxt = vstop_r;
    res_v     = 1'b0;
    res_kind  = KIND_UPDATE;
    res_idx   = '0;
    res_val   = '0;
    res_slave = '0;
    wr_en     = 1'b0;

    if (in_mode) begin
      // read-back leaves the parser untouched; data comes from the table port
      res_v    = 1'b1;
      res_kind = KIND_READ;
      res_idx  = in_query_index;
    end else if (fail_r) begin
      // any byte after 'F' names the slave
      fail_nxt  = 1'b0;
      res_v     = 1'b1;
      res_kind  = KIND_FAILURE;
      res_slave = in_rx_byte;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_rx_byte == CH_FAIL) begin
            fail_nxt = 1'b1;
          end else if (is_record_start(in_rx_byte)) begin
            idx_nxt   = {4'b0, hx.dig};
            istop_nxt = 1'b0;
            val_nxt   = '0;
            vstop_nxt = 1'b0;
            phase_nxt = PH_IDX2;
          end
        end
        PH_IDX2: begin
          if (!istop_r && hx.ok) begin
            idx_nxt = {idx_r[3:0], hx.dig};
          end else begin
            istop_nxt = 1'b1;
          end
          phase_nxt = PH_SEP;
        end
        PH_SEP: begin
          phase_nxt = PH_VAL1;
        end
        default: begin
          // value characters; the last one closes the record
          val_nxt   = val_new;
          vstop_nxt = vstop_new;
          if (phase_r < PH_VAL4) begin
            phase_nxt = phase_r + 3'd1;
          end else begin
            phase_nxt = PH_IDLE;
            res_v     = 1'b1;
            res_idx   = idx_r;
            if (idx_in_range) begin
              res_kind = KIND_UPDATE;
              res_val  = val_new;
              wr_en    = 1'b1;
            end else begin
              res_kind = KIND_BAD_INDEX;
            end
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      fail_r  <= 1'b0;
      idx_r   <= '0;
      istop_r <= 1'b0;
      val_r   <= '0;
      vstop_r <= 1'b0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      fail_r  <= fail_nxt;
      idx_r   <= idx_nxt;
      istop_r <= istop_nxt;
      val_r   <= val_nxt;
      vstop_r <= vstop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && res_v) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk) begin
    if (in_acc && res_v) begin
      out_kind_r  <= res_kind;
      out_idx_r   <= res_idx;
      out_val_r   <= res_val;
      out_slave_r <= res_slave;
    end
  end

  // table: one write port (record close), one registered read port (read-back)
  always_ff @(posedge clk) begin
    if (in_acc && wr_en) begin
      mem[wr_addr] <= val_new;
    end
    if (in_acc && in_mode) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // entry valid bits stand in for clearing the table at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_hit_r <= 1'b0;
    end else if (in_acc) begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (in_mode) begin
        rd_hit_r <= q_in_range && vld_r[rd_addr];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_slider_num   = out_idx_r;
  assign out_slider_value = (out_kind_r == KIND_READ) ? (rd_hit_r ? rd_data_r : 16'd0)
                                                      : out_val_r;
  assign out_failed_slave = out_slave_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `SLP_ASSERT_ALWAYS(a_fail_idle, (!rst_n || !fail_r || phase_r == PH_IDLE),
    "failure flag inside a record")
  `SLP_ASSERT(a_read_reply, (in_acc && in_mode) |=> (out_valid && out_kind == KIND_READ),
    "read request gave no read reply")
  `SLP_ASSERT(a_fail_reply,
    (in_acc && !in_mode && fail_r) |=> (out_valid && out_kind == KIND_FAILURE),
    "slave byte gave no failure result")
  `SLP_ASSERT(a_rec_close,
    (in_acc && !in_mode && !fail_r && phase_r == PH_VAL4) |=>
      (out_valid && (out_kind == KIND_UPDATE || out_kind == KIND_BAD_INDEX)),
    "record close gave no result")

endmodule

// ----- bench/tb_slider_record_parser.sv -----
// Testbench for slider_record_parser: directed and random byte streams, checked
// against an in-bench model of the record decoder and its slider table.
// Depends on slp_pkg and the slider_record_parser RTL.
module tb_slider_record_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import slp_pkg::*;

  localparam int SLIDER_COUNT = 16;
  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run

  // One decoded result as the out_ channel presents it.
  typedef struct {
    kind_t       kind;
    logic [7:0]  idx;
    logic [15:0] val;
    logic [7:0]  slave;
  } slider_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_mode = 1'b0;
  logic [7:0]  in_rx_byte = '0;
  logic [7:0]  in_query_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  kind_t       out_kind;
  logic [7:0]  out_slider_num;
  logic [15:0] out_slider_value;
  logic [7:0]  out_failed_slave;

  // Results the decoder must still deliver, oldest first.
  slider_result_t pending_results[$];

  // Bench copy of the decoder state.
  phase_t      rec_phase = PH_IDLE;
  logic        fail_pending = 1'b0;
  logic [7:0]  idx_acc = '0;
  logic        idx_stop = 1'b0;
  logic [15:0] val_acc = '0;
  logic        val_stop = 1'b0;
  logic [15:0] slider_tab [SLIDER_COUNT];

  int          err_count = 0;
  int          cycle_count = 0;
  int          src_idle_pct = 0;   // chance per cycle that the sender holds off
  int          sink_stall_pct = 0; // chance per cycle that the receiver stalls

  slider_record_parser #(.SLIDER_COUNT(SLIDER_COUNT)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_rx_byte       (in_rx_byte),
    .in_query_index   (in_query_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_slider_num   (out_slider_num),
    .out_slider_value (out_slider_value),
    .out_failed_slave (out_failed_slave)
  );

  always #1 clk = ~clk;

  // Global watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver back-pressure, drawn fresh every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    if (err_count < 40)
      $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
    err_count++;
  endtask

  // Hex digit value of a character, or -1 for anything that is not 0-9, a-f, A-F.
  function automatic int hex_val(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c) - int'(CH_0);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c) - int'(CH_LOWER_A) + 10;
    if (c >= CH_UPPER_A && c <= CH_FAIL) return int'(c) - int'(CH_UPPER_A) + 10;
    return -1;
  endfunction

  // Advance the bench decoder by one accepted request and queue what it yields.
  function automatic void predict_request(input logic mode, input logic [7:0] rx,
                                          input logic [7:0] q);
    slider_result_t r;
    int d;
    r = '{kind: KIND_READ, idx: 8'd0, val: 16'd0, slave: 8'd0};
    d = hex_val(rx);
    if (mode) begin
      // read-back never touches the parse state; out of range reads zero
      r.idx = q;
      r.val = (q < SLIDER_COUNT) ? slider_tab[q] : 16'd0;
      pending_results.push_back(r);
    end else if (fail_pending) begin
      // whatever byte follows 'F' names the slave
      fail_pending = 1'b0;
      r.kind  = KIND_FAILURE;
      r.slave = rx;
      pending_results.push_back(r);
    end else begin
      case (rec_phase)
        PH_IDLE: begin
          // only 'F' or a lowercase/decimal hex char opens a message
          if (rx == CH_FAIL) begin
            fail_pending = 1'b1;
          end else if ((rx >= CH_0 && rx <= CH_9) ||
                       (rx >= CH_LOWER_A && rx <= CH_LOWER_F)) begin
            idx_acc   = 8'(d);
            idx_stop  = 1'b0;
            val_acc   = '0;
            val_stop  = 1'b0;
            rec_phase = PH_IDX2;
          end
        end
        PH_IDX2: begin
          if (!idx_stop && d >= 0) idx_acc = {idx_acc[3:0], d[3:0]};
          else idx_stop = 1'b1;
          rec_phase = PH_SEP;
        end
        PH_SEP: begin
          rec_phase = PH_VAL1;  // separator is dropped
        end
        default: begin
          if (!val_stop && d >= 0) val_acc = {val_acc[11:0], d[3:0]};
          else val_stop = 1'b1;
          if (rec_phase != PH_VAL4) begin
            rec_phase = rec_phase + 3'd1;
          end else begin
            rec_phase = PH_IDLE;
            r.idx = idx_acc;
            if (idx_acc >= SLIDER_COUNT) begin
              r.kind = KIND_BAD_INDEX;  // table left alone
            end else begin
              r.kind = KIND_UPDATE;
              r.val  = val_acc;
              slider_tab[idx_acc] = val_acc;
            end
            pending_results.push_back(r);
          end
        end
      endcase
    end
  endfunction

  // Result checker. Sampled at the falling edge: everything is driven at the
  // rising edge, so these values hold until the edge that takes the result.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, kind", 0, out_kind);
      end else begin
        if (out_kind !== pending_results[0].kind)
          report_mismatch("kind", pending_results[0].kind, out_kind);
        if (out_slider_num !== pending_results[0].idx)
          report_mismatch("slider_num", pending_results[0].idx, out_slider_num);
        if (out_slider_value !== pending_results[0].val)
          report_mismatch("slider_value", pending_results[0].val, out_slider_value);
        if (out_failed_slave !== pending_results[0].slave)
          report_mismatch("failed_slave", pending_results[0].slave, out_failed_slave);
        void'(pending_results.pop_front());
      end
    end
  end

  // Send one request. Called at a rising-edge step, returns at one. Gaps are
  // inserted before the request; once valid is up the payload is held until taken.
  task automatic send_req(input logic mode, input logic [7:0] rx, input logic [7:0] q);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid       <= 1'b0;
      in_mode        <= 1'($urandom_range(1));
      in_rx_byte     <= 8'($urandom_range(255));
      in_query_index <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_rx_byte     <= rx;
    in_query_index <= q;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    // stall is low before the coming edge, so the request is taken there
    predict_request(mode, rx, q);
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] rx);
    send_req(1'b0, rx, 8'($urandom_range(255)));
  endtask

  task automatic send_query(input logic [7:0] q);
    send_req(1'b1, 8'($urandom_range(255)), q);
  endtask

  task automatic send_text(input string s);
    for (int k = 0; k < s.len(); k++) send_byte(s[k]);
  endtask

  // Drop valid and wait for every queued result, waiting on the clock before the first check.
  task automatic wait_results_drained;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic logic [7:0] hex_char(input int d, input logic upper);
    if (d < 10) return CH_0 + 8'(d);
    return (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] non_hex_byte;
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (hex_val(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] random_query;
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(SLIDER_COUNT - 1));
  endfunction

  // Seven-character record with random content; half start with '0' so the
  // index usually lands in the table. Non-hex chars now and then cut a field
  // short, and reads are slipped in mid-record.
  task automatic send_random_record;
    logic [7:0] ch;
    for (int k = 0; k < 7; k++) begin
      if (k == 0)
        ch = $urandom_range(1) ? CH_0 : hex_char($urandom_range(15), 1'b0);
      else if (k == 2)
        ch = 8'($urandom_range(255));
      else if ($urandom_range(11) == 0)
        ch = non_hex_byte();
      else
        ch = hex_char($urandom_range(15), 1'($urandom_range(1)));
      if ($urandom_range(15) == 0) send_query(random_query());
      send_byte(ch);
    end
  endtask

  // Table must read zero everywhere after reset, in and out of range.
  task automatic test_readback_after_reset;
    send_query(8'd0);
    send_query(8'(SLIDER_COUNT - 1));
    send_query(8'(SLIDER_COUNT));
    send_query(8'hFF);
  endtask

  // Failure messages: any byte after 'F' is the slave name, even 'F' itself;
  // a read inside the message leaves it pending.
  task automatic test_failure_messages;
    send_byte(CH_FAIL);
    send_byte(8'hFF);
    send_byte(CH_FAIL);
    send_byte(CH_FAIL);
    send_byte(CH_FAIL);
    send_query(8'd3);
    send_byte(8'h00);
  endtask

  // Records at the field extremes plus the early-stop cases.
  task automatic test_record_extremes;
    // bytes that open nothing are skipped
    send_byte(8'h00);
    send_byte(CH_UPPER_A);
    send_byte(8'hFF);
    // top table entry, all-ones value, high byte as separator
    send_text("0f");
    send_byte(8'h80);
    send_text("FFFF");
    send_query(8'(SLIDER_COUNT - 1));
    // index 0xff is out of range; 'F' inside a record is just a character
    send_text("ffF0000");
    // high byte stops the index at one digit, read mid-record, 'G' stops the value
    send_text("3");
    send_byte(8'hC5);
    send_text(":");
    send_query(8'd3);
    send_text("1G99");
  endtask

  // Mixed random traffic under one idle/stall setting.
  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    int sent;
    int pick;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_random_record();
        sent += 7;
      end else if (pick < 70) begin
        send_byte(CH_FAIL);
        if ($urandom_range(7) == 0) send_query(random_query());
        send_byte(8'($urandom_range(255)));
        sent += 2;
      end else if (pick < 85) begin
        send_query(random_query());
        sent++;
      end else begin
        send_byte(8'($urandom_range(255)));  // noise, may also open a broken message
        sent++;
      end
    end
    wait_results_drained();
  endtask

  initial begin
    for (int k = 0; k < SLIDER_COUNT; k++) slider_tab[k] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_readback_after_reset();
    test_failure_messages();
    test_record_extremes();
    wait_results_drained();

    test_random_traffic(125, 0, 0);
    test_random_traffic(125, 88, 0);
    test_random_traffic(125, 0, 88);
    test_random_traffic(125, 8, 8);

    // with traffic stopped, the checker catches any stray output and nothing may stay pending
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
